>>> rtl/clns_pkg.sv
`default_nettype none

package clns_pkg;

	// Field widths of the request and result items.
	localparam int OP_W     = 3;
	localparam int CHAR_W   = 8;
	localparam int NUM_W    = 10;
	localparam int CNT_W    = 5;
	localparam int NIB_W    = 4;

	// Default saturation limit of the shift repeat count.
	localparam int SHIFT_MAX_DEF = 31;

	// Largest number that is shown; larger values saturate to it.
	localparam logic [NUM_W-1:0] NUM_MAX = 10'd999;

	// Width of the microcode step counter.
	localparam int PC_W = 5;

	// Reciprocal constants for the digit split.
	// The value divided by 100 is (v * 41) >> 12, exact for v up to 999.
	// The value divided by 10 is (v * 205) >> 11, exact for v up to 99.
	localparam int              D100_PROD_W = 16;
	localparam logic [5:0]      D100_MUL    = 6'd41;
	localparam int              D100_SH     = 12;
	localparam int              D10_IN_W    = 7;
	localparam int              D10_PROD_W  = 15;
	localparam logic [7:0]      D10_MUL     = 8'd205;
	localparam int              D10_SH      = 11;

	// Command nibbles of the display shift instruction.
	localparam logic [NIB_W-1:0] NIB_SHL = 4'h8;
	localparam logic [NIB_W-1:0] NIB_SHR = 4'hC;

	// Request operation codes.
	typedef enum logic [OP_W-1:0] {
		OP_CHAR  = 3'd0,
		OP_NUM   = 3'd1,
		OP_INIT  = 3'd2,
		OP_CLEAR = 3'd3,
		OP_HOME  = 3'd4,
		OP_SHL   = 3'd5,
		OP_SHR   = 3'd6
	} op_t;

	// Source of the nibble driven by a step.
	typedef enum logic [2:0] {
		NS_CONST,
		NS_CHAR_HI,
		NS_CHAR_LO,
		NS_DIGIT,
		NS_SHIFT
	} nsel_t;

	// Datapath operation performed alongside a step.
	typedef enum logic [2:0] {
		DOP_NONE,
		DOP_DIV100,
		DOP_SUB100,
		DOP_DIV10,
		DOP_SUB10,
		DOP_UNITS
	} dop_t;

	// Sequencing of the step counter after a step.
	typedef enum logic [1:0] {
		FL_NEXT,
		FL_END,
		FL_LOOP
	} flow_t;

	// One control word of the program.
	typedef struct packed {
		logic              rs;
		nsel_t             nsel;
		logic [NIB_W-1:0]  konst;
		dop_t              dop;
		flow_t             flow;
		logic [PC_W-1:0]   target;
	} uword_t;

	// Control from the sequencer to the datapath for one step.
	typedef struct packed {
		logic   fire;
		logic   last;
		uword_t word;
	} step_t;

	// Program entry points.
	localparam logic [PC_W-1:0] PC_CHAR  = 5'd0;
	localparam logic [PC_W-1:0] PC_NUM   = 5'd2;
	localparam logic [PC_W-1:0] PC_INIT  = 5'd8;
	localparam logic [PC_W-1:0] PC_CLEAR = 5'd19;
	localparam logic [PC_W-1:0] PC_HOME  = 5'd21;
	localparam logic [PC_W-1:0] PC_SHIFT = 5'd23;

	function automatic uword_t uw(logic rs, nsel_t ns, logic [NIB_W-1:0] k, dop_t d,
			flow_t f, logic [PC_W-1:0] t);
		uword_t w;
		w.rs     = rs;
		w.nsel   = ns;
		w.konst  = k;
		w.dop    = d;
		w.flow   = f;
		w.target = t;
		return w;
	endfunction

	// The program: one control word per step.
	function automatic uword_t ucode(logic [PC_W-1:0] pc);
		uword_t w;
		unique case (pc)
			// Character: high nibble, then low nibble.
			5'd0:  w = uw(1'b1, NS_CHAR_HI, 4'h0, DOP_NONE,   FL_NEXT, PC_CHAR);
			5'd1:  w = uw(1'b1, NS_CHAR_LO, 4'h0, DOP_NONE,   FL_END,  PC_CHAR);
			// Number: each digit as 0x30 plus the digit, digits split on the way.
			5'd2:  w = uw(1'b1, NS_CONST,   4'h3, DOP_DIV100, FL_NEXT, PC_NUM);
			5'd3:  w = uw(1'b1, NS_DIGIT,   4'h0, DOP_SUB100, FL_NEXT, PC_NUM);
			5'd4:  w = uw(1'b1, NS_CONST,   4'h3, DOP_DIV10,  FL_NEXT, PC_NUM);
			5'd5:  w = uw(1'b1, NS_DIGIT,   4'h0, DOP_SUB10,  FL_NEXT, PC_NUM);
			5'd6:  w = uw(1'b1, NS_CONST,   4'h3, DOP_UNITS,  FL_NEXT, PC_NUM);
			5'd7:  w = uw(1'b1, NS_DIGIT,   4'h0, DOP_NONE,   FL_END,  PC_NUM);
			// Power-up sequence.
			5'd8:  w = uw(1'b0, NS_CONST,   4'h3, DOP_NONE,   FL_NEXT, PC_INIT);
			5'd9:  w = uw(1'b0, NS_CONST,   4'h2, DOP_NONE,   FL_NEXT, PC_INIT);
			5'd10: w = uw(1'b0, NS_CONST,   4'hC, DOP_NONE,   FL_NEXT, PC_INIT);
			5'd11: w = uw(1'b0, NS_CONST,   4'h2, DOP_NONE,   FL_NEXT, PC_INIT);
			5'd12: w = uw(1'b0, NS_CONST,   4'hC, DOP_NONE,   FL_NEXT, PC_INIT);
			5'd13: w = uw(1'b0, NS_CONST,   4'h0, DOP_NONE,   FL_NEXT, PC_INIT);
			5'd14: w = uw(1'b0, NS_CONST,   4'hF, DOP_NONE,   FL_NEXT, PC_INIT);
			5'd15: w = uw(1'b0, NS_CONST,   4'h0, DOP_NONE,   FL_NEXT, PC_INIT);
			5'd16: w = uw(1'b0, NS_CONST,   4'h1, DOP_NONE,   FL_NEXT, PC_INIT);
			5'd17: w = uw(1'b0, NS_CONST,   4'h0, DOP_NONE,   FL_NEXT, PC_INIT);
			5'd18: w = uw(1'b0, NS_CONST,   4'h6, DOP_NONE,   FL_END,  PC_INIT);
			// Clear, then falls through into home.
			5'd19: w = uw(1'b0, NS_CONST,   4'h0, DOP_NONE,   FL_NEXT, PC_CLEAR);
			5'd20: w = uw(1'b0, NS_CONST,   4'h1, DOP_NONE,   FL_NEXT, PC_CLEAR);
			5'd21: w = uw(1'b0, NS_CONST,   4'h0, DOP_NONE,   FL_NEXT, PC_HOME);
			5'd22: w = uw(1'b0, NS_CONST,   4'h2, DOP_NONE,   FL_END,  PC_HOME);
			// Display shift, repeated while the count lasts.
			5'd23: w = uw(1'b0, NS_CONST,   4'h1, DOP_NONE,   FL_NEXT, PC_SHIFT);
			5'd24: w = uw(1'b0, NS_SHIFT,   4'h0, DOP_NONE,   FL_LOOP, PC_SHIFT);
			default: w = uw(1'b0, NS_CONST, 4'h0, DOP_NONE,   FL_END,  PC_CHAR);
		endcase
		return w;
	endfunction

	// Entry point of each operation.
	function automatic logic [PC_W-1:0] entry_pc(op_t op);
		logic [PC_W-1:0] pc;
		unique case (op)
			OP_CHAR:         pc = PC_CHAR;
			OP_NUM:          pc = PC_NUM;
			OP_INIT:         pc = PC_INIT;
			OP_CLEAR:        pc = PC_CLEAR;
			OP_HOME:         pc = PC_HOME;
			OP_SHL, OP_SHR:  pc = PC_SHIFT;
			default:         pc = PC_CHAR;
		endcase
		return pc;
	endfunction

endpackage

`default_nettype wire

>>> rtl/clns_if.sv
`default_nettype none

// Request channel: one operation with its operands.
interface clns_req_if;
	logic                          valid;
	logic                          ready;
	logic [clns_pkg::OP_W-1:0]     op;
	logic [clns_pkg::CHAR_W-1:0]   char_byte;
	logic [clns_pkg::NUM_W-1:0]    number;
	logic [clns_pkg::CNT_W-1:0]    shift_count;

	modport source (output valid, output op, output char_byte, output number,
		output shift_count, input ready);
	modport sink (input valid, input op, input char_byte, input number,
		input shift_count, output ready);
endinterface

// Result channel: one nibble transfer per enable strobe.
interface clns_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          reg_select;
	logic [clns_pkg::NIB_W-1:0]    nibble;
	logic                          last;

	modport source (output valid, output reg_select, output nibble, output last,
		input ready);
	modport sink (input valid, input reg_select, input nibble, input last,
		output ready);
endinterface

`default_nettype wire

>>> rtl/clns_seq.sv
`default_nettype none

module clns_seq #(
	parameter int SHIFT_MAX = clns_pkg::SHIFT_MAX_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        accept,
	input  wire logic [clns_pkg::OP_W-1:0]   op,
	input  wire logic [clns_pkg::CNT_W-1:0]  shift_count,
	input  wire logic                        out_free,
	output      logic                        busy,
	output      clns_pkg::step_t             step
);
	import clns_pkg::*;

	logic             busy_q;
	logic [PC_W-1:0]  pc_q;
	logic [CNT_W-1:0] cnt_q;
	uword_t           word;
	logic [CNT_W-1:0] cnt_sat;
	logic             starts;
	logic             more;
	op_t              op_l;

	assign op_l = op_t'(op);
	assign word = ucode(pc_q);
	assign busy = busy_q;

	// Saturate the repeat count.
	assign cnt_sat = (shift_count > CNT_W'(SHIFT_MAX)) ? CNT_W'(SHIFT_MAX) : shift_count;

	// A request starts a run unless it has nothing to send.
	always_comb begin
		unique case (op_l) inside
			OP_CHAR, OP_NUM, OP_INIT, OP_CLEAR, OP_HOME: starts = 1'b1;
			OP_SHL, OP_SHR:                              starts = (cnt_sat != '0);
			default:                                     starts = 1'b0;
		endcase
	end

	// A loop step repeats while more than one pass remains.
	assign more = (word.flow == FL_LOOP) && (cnt_q > CNT_W'(1));

	assign step.fire = busy_q && out_free;
	assign step.word = word;
	assign step.last = (word.flow == FL_END) || ((word.flow == FL_LOOP) && !more);

	// Step counter and repeat counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			busy_q <= starts;
			pc_q   <= entry_pc(op_l);
			cnt_q  <= cnt_sat;
		end else if (step.fire) begin
			unique case (word.flow)
				FL_NEXT: pc_q <= pc_q + PC_W'(1);
				FL_END:  busy_q <= 1'b0;
				FL_LOOP: begin
					if (more) begin
						pc_q  <= word.target;
						cnt_q <= cnt_q - CNT_W'(1);
					end else begin
						busy_q <= 1'b0;
					end
				end
				default: busy_q <= 1'b0;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/clns_dpath.sv
`default_nettype none

module clns_dpath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         accept,
	input  wire logic [clns_pkg::OP_W-1:0]    op,
	input  wire logic [clns_pkg::CHAR_W-1:0]  char_byte,
	input  wire logic [clns_pkg::NUM_W-1:0]   number,
	input  wire clns_pkg::step_t              step,
	input  wire logic                         out_ready,
	output      logic                         out_valid,
	output      logic                         out_rs,
	output      logic [clns_pkg::NIB_W-1:0]   out_nibble,
	output      logic                         out_last,
	output      logic                         out_free
);
	import clns_pkg::*;

	logic [CHAR_W-1:0]      char_q;
	logic [NUM_W-1:0]       val_q;
	logic [NIB_W-1:0]       digit_q;
	logic                   dir_q;
	logic                   valid_q;
	logic                   rs_q;
	logic [NIB_W-1:0]       nib_q;
	logic                   last_q;
	logic [D100_PROD_W-1:0] prod100;
	logic [D10_PROD_W-1:0]  prod10;
	logic [NIB_W-1:0]       nib_sel;

	// Reciprocal multiplies for the digit split.
	assign prod100 = D100_PROD_W'(val_q) * D100_PROD_W'(D100_MUL);
	assign prod10  = D10_PROD_W'(val_q[D10_IN_W-1:0]) * D10_PROD_W'(D10_MUL);

	// Operand registers, loaded on a request and worked by the program.
	always_ff @(posedge clk) begin
		if (accept) begin
			char_q <= char_byte;
			val_q  <= (number > NUM_MAX) ? NUM_MAX : number;
			dir_q  <= (op_t'(op) == OP_SHR);
		end else if (step.fire) begin
			unique case (step.word.dop)
				DOP_NONE:   ;
				DOP_DIV100: digit_q <= prod100[D100_SH+NIB_W-1:D100_SH];
				DOP_SUB100: val_q   <= val_q - NUM_W'(digit_q) * NUM_W'(100);
				DOP_DIV10:  digit_q <= prod10[D10_SH+NIB_W-1:D10_SH];
				DOP_SUB10:  val_q   <= val_q - NUM_W'(digit_q) * NUM_W'(10);
				DOP_UNITS:  digit_q <= val_q[NIB_W-1:0];
				default:    ;
			endcase
		end
	end

	// Nibble source for the current step.
	always_comb begin
		unique case (step.word.nsel)
			NS_CONST:   nib_sel = step.word.konst;
			NS_CHAR_HI: nib_sel = char_q[CHAR_W-1:NIB_W];
			NS_CHAR_LO: nib_sel = char_q[NIB_W-1:0];
			NS_DIGIT:   nib_sel = digit_q;
			NS_SHIFT:   nib_sel = dir_q ? NIB_SHR : NIB_SHL;
			default:    nib_sel = step.word.konst;
		endcase
	end

	// Output register: a step may load it while the held result drains.
	assign out_free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step.fire) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step.fire) begin
			rs_q   <= step.word.rs;
			nib_q  <= nib_sel;
			last_q <= step.last;
		end
	end

	assign out_valid  = valid_q;
	assign out_rs     = rs_q;
	assign out_nibble = nib_q;
	assign out_last   = last_q;

endmodule

`default_nettype wire

>>> rtl/char_lcd_nibble_sequencer_unit.sv
`default_nettype none

// Channel  Direction  Payload                                Handshake
// req      in         op, char_byte, number, shift_count     valid / ready
// rsp      out        reg_select, nibble, last               valid / ready
//
// A request of n transfers issues one transfer per cycle while rsp is taken:
// after acceptance, the step counter reads one control word from the program
// table per transfer.
// req is ready again once the last control word has issued; the final
// transfer may still sit in the output register while the next request enters.
// A stall on rsp holds the step counter. Reset leaves the block idle.
module char_lcd_nibble_sequencer_unit #(
	parameter int SHIFT_MAX = clns_pkg::SHIFT_MAX_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	clns_req_if.sink  req,
	clns_rsp_if.source rsp
);
	import clns_pkg::*;

	logic  busy;
	logic  accept;
	logic  out_free;
	step_t step;

	assign req.ready = !busy;
	assign accept    = req.valid && !busy;

	// Step counter and program table.
	clns_seq #(
		.SHIFT_MAX (SHIFT_MAX)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.op          (req.op),
		.shift_count (req.shift_count),
		.out_free    (out_free),
		.busy        (busy),
		.step        (step)
	);

	// Operands, digit split and output register.
	clns_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.op         (req.op),
		.char_byte  (req.char_byte),
		.number     (req.number),
		.step       (step),
		.out_ready  (rsp.ready),
		.out_valid  (rsp.valid),
		.out_rs     (rsp.reg_select),
		.out_nibble (rsp.nibble),
		.out_last   (rsp.last),
		.out_free   (out_free)
	);

endmodule

`default_nettype wire
